/* hdl/rpl_pkg.sv */
package rpl_pkg;
  localparam int unsigned CELLS   = 4096;
  localparam int unsigned QUERIES = 4096;
  localparam int unsigned IW  = $clog2(CELLS + 2);
  localparam int unsigned QAW = $clog2(QUERIES);
  localparam int unsigned QCW = $clog2(QUERIES + 1);
  localparam int unsigned FW  = 13;
  localparam int unsigned CW  = 32;

  typedef enum logic [1:0] {
    OP_PAINT   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;
endpackage

/* hdl/range_paint_last_writer_wins.sv */
// Paint and unused opcodes give their word in the cycle after accept; a read passes S_RDWAIT
// (color memory read port) first, taking no new input meanwhile. Throughput: one paint per
// cycle while the output is not stalled. A resolve stalls the input while it clears the memories
// (S_CLR), reads each stored query newest first (S_QRD, S_QWAIT), walks its clamped range if not
// empty, painting each cell or jumping each painted run (S_PRD, S_PEVAL), then presents its word
// after a closing S_QRD. Reset is asynchronous and active low; reads return zero until the first resolve clears.
module range_paint_last_writer_wins (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,  // opcode
  input  logic [63:0] s_axis_tdata_i,  // range_start, range_end, paint_color, zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // cell_color, store_full, zero fill
);
  import rpl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDWAIT, S_CLR, S_QRD, S_QWAIT, S_PRD, S_PEVAL
  } state_e;

  state_e          state_q;
  logic [FW-1:0]   len_q;
  logic [QCW-1:0]  cnt_q, k_q;
  logic [IW-1:0]   p_q, e_q;
  logic [CW-1:0]   c_q;
  logic            ov_q, full_q, rd_ok_q, clean_q;
  logic [CW-1:0]   ocolor_q;

  logic [2*FW+CW-1:0] qmem [0:QUERIES-1];
  logic [CW-1:0]      cmem [0:CELLS];
  logic [IW-1:0]      nmem [0:CELLS+1];
  logic [2*FW+CW-1:0] q_rd;
  logic [CW-1:0]      c_rd;
  logic [IW-1:0]      n_rd;

  logic [1:0]    op;
  logic [FW-1:0] a, len, qs, qe, cs, ce;
  logic          acc, out_free;

  assign op  = s_axis_tuser_i;
  assign a   = s_axis_tdata_i[FW-1:0];
  assign len = (len_q > FW'(CELLS)) ? FW'(CELLS) : len_q;
  assign out_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign qs = q_rd[FW-1:0];
  assign qe = q_rd[2*FW-1:FW];
  assign cs = (qs == '0) ? FW'(1) : qs;
  assign ce = (qe > len) ? len : qe;

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {7'd0, full_q, ocolor_q};

  always_ff @(posedge clk_i) begin
    if (acc && op == OP_PAINT && cnt_q != QCW'(QUERIES)) begin
      qmem[cnt_q[QAW-1:0]] <= s_axis_tdata_i[2*FW+CW-1:0];
    end
    if (state_q == S_QRD && k_q != '0) begin
      q_rd <= qmem[QAW'(k_q - QCW'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      nmem[p_q] <= p_q;
      if (p_q <= IW'(CELLS)) begin
        cmem[p_q] <= '0;
      end
    end else if (state_q == S_PEVAL && n_rd <= e_q) begin
      nmem[p_q] <= e_q + IW'(1);
      if (n_rd == p_q) begin
        cmem[p_q] <= c_q;
      end
    end
    if (state_q == S_PRD) begin
      n_rd <= nmem[p_q];
    end
    if (acc && op == OP_READ) begin
      c_rd <= cmem[IW'(a)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= FW'(4096);
      cnt_q   <= '0;
      k_q     <= '0;
      p_q     <= '0;
      e_q     <= '0;
      c_q     <= '0;
      ov_q    <= 1'b0;
      full_q  <= 1'b0;
      rd_ok_q <= 1'b0;
      clean_q <= 1'b0;
      ocolor_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (ov_q && m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (op)
              OP_PAINT: begin
                ov_q     <= 1'b1;
                ocolor_q <= '0;
                full_q   <= (cnt_q == QCW'(QUERIES));
                if (cnt_q != QCW'(QUERIES)) begin
                  cnt_q <= cnt_q + QCW'(1);
                end
              end
              OP_RESOLVE: begin
                p_q     <= '0;
                state_q <= S_CLR;
              end
              OP_READ: begin
                rd_ok_q <= clean_q && (a >= FW'(1)) && (a <= len);
                state_q <= S_RDWAIT;
              end
              default: begin
                ov_q     <= 1'b1;
                ocolor_q <= '0;
                full_q   <= 1'b0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          ov_q     <= 1'b1;
          full_q   <= 1'b0;
          ocolor_q <= rd_ok_q ? c_rd : '0;
          state_q  <= S_IDLE;
        end
        S_CLR: begin
          if (p_q == IW'(CELLS + 1)) begin
            k_q     <= cnt_q;
            clean_q <= 1'b1;
            state_q <= S_QRD;
          end else begin
            p_q <= p_q + IW'(1);
          end
        end
        S_QRD: begin
          if (k_q == '0) begin
            cnt_q    <= '0;
            ov_q     <= 1'b1;
            full_q   <= 1'b0;
            ocolor_q <= '0;
            state_q  <= S_IDLE;
          end else begin
            k_q     <= k_q - QCW'(1);
            state_q <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          p_q <= IW'(cs);
          e_q <= IW'(ce);
          c_q <= q_rd[2*FW+CW-1:2*FW];
          state_q <= (cs > ce) ? S_QRD : S_PRD;
        end
        S_PRD: begin
          state_q <= (p_q > e_q) ? S_QRD : S_PEVAL;
        end
        S_PEVAL: begin
          p_q     <= (n_rd == p_q) ? p_q + IW'(1) : n_rd;
          state_q <= S_PRD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/rpl_checker.sv */
module rpl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);
  import rpl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[31:0] == '0)
    else $error("dropped paint carries a color");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("input taken while a word is stuck");

  a_paint_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_PAINT |=> m_axis_tvalid_o)
    else $error("paint gave no word");
endmodule

bind range_paint_last_writer_wins rpl_checker u_rpl_checker (.*);

/* sim/range_paint_last_writer_wins_tb.sv */
module range_paint_last_writer_wins_tb;
  import rpl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] color;
    logic        full;
  } answer_t;

  typedef struct {
    opcode_e     op;
    logic [12:0] first;
    logic [12:0] last;
    logic [31:0] color;
    bit          typed;
    answer_t     answer;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [1:0]  s_axis_tuser_i = '0;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  range_paint_last_writer_wins uut (.*);

  always #2 clk_i = ~clk_i;

  logic [12:0] q_first [QUERIES];
  logic [12:0] q_last [QUERIES];
  logic [31:0] q_color [QUERIES];
  int unsigned q_count;
  logic [31:0] paint [CELLS + 1];
  int unsigned next_free [CELLS + 2];
  logic [12:0] cell_limit;

  answer_t awaited [$];
  int unsigned mismatches = 0;
  bit calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;

  function automatic int unsigned find_free(int unsigned p);
    int unsigned r;
    int unsigned t;
    r = p;
    while (next_free[r] != r) r = next_free[r];
    while (next_free[p] != r) begin
      t = next_free[p];
      next_free[p] = r;
      p = t;
    end
    return r;
  endfunction

  function automatic answer_t paint_step(opcode_e op, logic [12:0] a, logic [12:0] b,
                                         logic [31:0] c);
    answer_t res;
    int unsigned len;
    int unsigned s;
    int unsigned e;
    int unsigned i;
    res = '0;
    len = (cell_limit > CELLS) ? CELLS : cell_limit;
    case (op)
      OP_PAINT: begin
        if (q_count >= QUERIES) begin
          res.full = 1'b1;
        end else begin
          q_first[q_count] = a;
          q_last[q_count] = b;
          q_color[q_count] = c;
          q_count++;
        end
      end
      OP_RESOLVE: begin
        foreach (paint[k]) paint[k] = '0;
        foreach (next_free[k]) next_free[k] = k;
        for (int k = int'(q_count) - 1; k >= 0; k--) begin
          s = (q_first[k] == 0) ? 1 : q_first[k];
          e = (q_last[k] > len) ? len : q_last[k];
          if (s <= e) begin
            i = find_free(s);
            while (i <= e) begin
              paint[i] = q_color[k];
              next_free[i] = e + 1;
              i = find_free(i + 1);
            end
          end
        end
        q_count = 0;
      end
      OP_READ: begin
        if (a >= 1 && a <= len) res.color = paint[a];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_word(opcode_e op, logic [12:0] a, logic [12:0] b, logic [31:0] c,
                           bit typed, answer_t answer);
    answer_t want;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {6'b0, c, b, a};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    want = paint_step(op, a, b, c);
    awaited = {awaited, (typed ? answer : want)};
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_length(logic [12:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cell_limit = v;
    @(posedge clk_i);
  endtask

  task automatic random_word(int unsigned len);
    opcode_e op;
    int unsigned pick;
    logic [12:0] a;
    logic [12:0] b;
    int unsigned top;
    pick = $urandom_range(0, 99);
    if (pick < 55) op = OP_PAINT;
    else if (pick < 90) op = OP_READ;
    else if (pick < 95) op = OP_RESOLVE;
    else op = OP_NONE;
    top = (len == 0) ? 1 : len;
    if ($urandom_range(0, 9) == 0) begin
      a = 13'($urandom_range(0, 8191));
      b = 13'($urandom_range(0, 8191));
    end else begin
      a = 13'($urandom_range(1, top));
      b = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(1, top) :
              ((a + $urandom_range(0, 40) > top) ? top : a + $urandom_range(0, 40)));
    end
    push_word(op, a, b, $urandom, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.color = m_axis_tdata_o[31:0];
      got.full = m_axis_tdata_o[32];
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word color=%h full=%b", got.color, got.full);
      end else begin
        want = awaited.pop_front();
        if (got !== want || m_axis_tdata_o[39:33] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected color=%h full=%b, got color=%h full=%b",
                     want.color, want.full, got.color, got.full);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  row_t rows [$];
  logic [12:0] lengths [5];

  initial begin
    q_count = 0;
    cell_limit = 13'd4096;
    foreach (paint[k]) paint[k] = '0;
    foreach (next_free[k]) next_free[k] = k;

    rows = '{
      '{OP_READ,    13'd1,    13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_READ,    13'd0,    13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_NONE,    13'd8191, 13'd8191, 32'hFFFFFFFF,  1'b1, '{32'h0, 1'b0}},
      '{OP_PAINT,   13'd1,    13'd4096, 32'hFFFFFFFF,  1'b1, '{32'h0, 1'b0}},
      '{OP_PAINT,   13'd0,    13'd8191, 32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_PAINT,   13'd9,    13'd3,    32'h12345678,  1'b1, '{32'h0, 1'b0}},
      '{OP_PAINT,   13'd10,   13'd20,   32'hAAAA5555,  1'b1, '{32'h0, 1'b0}},
      '{OP_PAINT,   13'd15,   13'd30,   32'h5555AAAA,  1'b1, '{32'h0, 1'b0}},
      '{OP_PAINT,   13'd4096, 13'd4096, 32'hC0FFEE00,  1'b1, '{32'h0, 1'b0}},
      '{OP_READ,    13'd10,   13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_RESOLVE, 13'd0,    13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_READ,    13'd1,    13'd0,    32'h0,         1'b0, '{32'h0, 1'b0}},
      '{OP_READ,    13'd10,   13'd0,    32'h0,         1'b0, '{32'h0, 1'b0}},
      '{OP_READ,    13'd15,   13'd0,    32'h0,         1'b0, '{32'h0, 1'b0}},
      '{OP_READ,    13'd30,   13'd0,    32'h0,         1'b0, '{32'h0, 1'b0}},
      '{OP_READ,    13'd31,   13'd0,    32'h0,         1'b0, '{32'h0, 1'b0}},
      '{OP_READ,    13'd4096, 13'd0,    32'h0,         1'b0, '{32'h0, 1'b0}},
      '{OP_READ,    13'd4097, 13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_READ,    13'd8191, 13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_READ,    13'd0,    13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_RESOLVE, 13'd0,    13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}},
      '{OP_READ,    13'd4096, 13'd0,    32'h0,         1'b1, '{32'h0, 1'b0}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r])
      push_word(rows[r].op, rows[r].first, rows[r].last, rows[r].color, rows[r].typed,
                rows[r].answer);

    lengths = '{13'd1, 13'd0, 13'd8191, 13'($urandom_range(2, 300)), 13'd4096};
    foreach (lengths[p]) begin
      set_length(lengths[p]);
      if (p == 4) calm = 1'b1;
      for (int n = 0; n < 115; n++)
        random_word((lengths[p] > CELLS) ? CELLS : ((lengths[p] > 300) ? 300 : lengths[p]));
      push_word(OP_RESOLVE, 13'd0, 13'd0, 32'h0, 1'b0, '0);
      for (int n = 0; n < 10; n++)
        push_word(OP_READ, 13'($urandom_range(0, 310)), 13'd0, 32'h0, 1'b0, '0);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
